/* rtl/sts_pkg.sv */
package sts_pkg;

  // Field and register widths
  localparam int VALUE_W = 32;
  localparam int INDEX_W = 10;
  localparam int SIZE_W  = 11;
  localparam int CFG_W   = 11;

  localparam int DEFAULT_TABLE_DEPTH = 1024;

  // Configuration register indexes
  localparam logic CFG_USED_SIZE = 1'b0;
  localparam logic CFG_METHOD    = 1'b1;

  // Search methods
  localparam logic METHOD_BINARY = 1'b0;
  localparam logic METHOD_INTERP = 1'b1;

  // Item commands
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

endpackage

/* rtl/sts_div.sv */
// Restoring divider, one quotient bit per cycle.
// The quotient is known to fit in QUOT_W bits, so the upper part of the
// numerator is already below the divisor and seeds the partial remainder.
module sts_div #(
  parameter int QUOT_W = 10
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [QUOT_W+sts_pkg::VALUE_W-1:0]   num,
  input  logic [sts_pkg::VALUE_W-1:0]          den,
  output logic                                 done,
  output logic [QUOT_W-1:0]                    quot
);
  import sts_pkg::*;

  localparam int CNT_W = $clog2(QUOT_W + 1);

  logic [VALUE_W-1:0] rem;
  logic [VALUE_W-1:0] rem_next;
  logic [QUOT_W-1:0]  qsh;
  logic [QUOT_W-1:0]  qsh_next;
  logic [CNT_W-1:0]   cnt;
  logic               busy;
  logic [VALUE_W:0]   trial;
  logic [VALUE_W:0]   diff;
  logic               take;

  // Shift in the next numerator bit and try to subtract the divisor
  always_comb begin
    trial    = {rem, qsh[QUOT_W-1]};
    diff     = trial - {1'b0, den};
    take     = (trial >= {1'b0, den});
    rem_next = take ? diff[VALUE_W-1:0] : trial[VALUE_W-1:0];
    qsh_next = QUOT_W'({qsh, take});
  end

  // Control: load on start, count down the quotient bits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(QUOT_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: partial remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num[QUOT_W+VALUE_W-1:QUOT_W];
      qsh <= num[QUOT_W-1:0];
    end else if (busy) begin
      rem <= rem_next;
      qsh <= qsh_next;
    end
  end

  assign quot = qsh;

endmodule

/* rtl/sorted_table_search_core.sv */
// Write: no result. Search: one result; the next item is taken the cycle after the
// result loads, so items run one at a time.
// Binary: each probe reads the middle entry, then compares; a miss ends on the bound
// check, and the result then loads. Reset keeps the table content.
// Interpolation: each probe reads the ends, checks, multiplies, divides in the restoring
// divider, then probes and compares; equal end entries skip the multiply and divide.
module sorted_table_search_core #(
  parameter int TABLE_DEPTH = sts_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [sts_pkg::CFG_W-1:0]     cfg_data,
  // Items
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic                          cmd,
  input  logic [sts_pkg::INDEX_W-1:0]   entry_index,
  input  logic signed [sts_pkg::VALUE_W-1:0] value,
  // Results
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic                          found,
  output logic [sts_pkg::INDEX_W-1:0]   position
);
  import sts_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int IW = AW + 2;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_BPROBE = 10'b00_0000_0010,
    S_ILO    = 10'b00_0000_0100,
    S_IHI    = 10'b00_0000_1000,
    S_ICHK   = 10'b00_0001_0000,
    S_IMUL   = 10'b00_0010_0000,
    S_IDIV   = 10'b00_0100_0000,
    S_IPROBE = 10'b00_1000_0000,
    S_CMP    = 10'b01_0000_0000,
    S_DONE   = 10'b10_0000_0000
  } state_t;

  localparam logic signed [IW-1:0] ONE = IW'(1);

  state_t state;
  state_t state_next;

  logic [SIZE_W-1:0] used_size;
  logic              method;

  logic [VALUE_W-1:0]        mem [TABLE_DEPTH];
  logic                      we;
  logic [AW-1:0]             raddr;
  logic signed [VALUE_W-1:0] rdata;

  logic signed [IW-1:0]      lo;
  logic signed [IW-1:0]      hi;
  logic signed [VALUE_W-1:0] key;
  logic signed [VALUE_W-1:0] el;
  logic [VALUE_W-1:0]        den;
  logic [VALUE_W-1:0]        kdiff;
  logic [AW-1:0]             qoff;
  logic [AW-1:0]             probe;
  logic                      res_found;
  logic [INDEX_W-1:0]        res_pos;

  logic signed [IW-1:0]      n_sat;
  logic signed [IW-1:0]      mid;
  logic [IW-1:0]             span_full;
  logic [AW-1:0]             span;
  logic signed [IW-1:0]      probe_i;
  logic signed [VALUE_W:0]   end_diff;
  logic signed [VALUE_W:0]   key_diff;
  logic [AW+VALUE_W-1:0]     num;
  logic                      div_start;
  logic                      div_done;
  logic [AW-1:0]             div_quot;
  logic                      load_result;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      used_size <= '0;
      method    <= METHOD_BINARY;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_USED_SIZE: used_size <= cfg_data[SIZE_W-1:0];
        CFG_METHOD:    method    <= cfg_data[0];
        default:       used_size <= used_size;
      endcase
    end
  end

  // Table memory: one write port, one registered read port
  assign we = (state == S_IDLE) && item_valid && (cmd == CMD_WRITE) &&
              (32'(entry_index) < 32'(TABLE_DEPTH));

  always_ff @(posedge clk) begin
    if (we) begin
      mem[AW'(entry_index)] <= value;
    end
    rdata <= mem[raddr];
  end

  // Index arithmetic
  always_comb begin
    n_sat     = (32'(used_size) > 32'(TABLE_DEPTH)) ? IW'(TABLE_DEPTH) : IW'(used_size);
    span_full = hi - lo;
    span      = span_full[AW-1:0];
    mid       = lo + $signed(span_full >> 1);
    probe_i   = $signed({2'b00, probe});
    end_diff  = (VALUE_W+1)'(rdata) - (VALUE_W+1)'(el);
    key_diff  = (VALUE_W+1)'(key) - (VALUE_W+1)'(el);
    num       = span * kdiff;
  end

  // Read address per state
  always_comb begin
    case (state)
      S_BPROBE: raddr = mid[AW-1:0];
      S_ILO:    raddr = lo[AW-1:0];
      S_IHI:    raddr = hi[AW-1:0];
      S_IPROBE: raddr = lo[AW-1:0] + qoff;
      default:  raddr = '0;
    endcase
  end

  assign div_start = (state == S_IMUL);

  sts_div #(
    .QUOT_W (AW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (item_valid && (cmd == CMD_SEARCH)) begin
          state_next = (method == METHOD_INTERP) ? S_ILO : S_BPROBE;
        end
      end
      S_BPROBE: state_next = (lo > hi) ? S_DONE : S_CMP;
      S_ILO:    state_next = (lo > hi) ? S_DONE : S_IHI;
      S_IHI:    state_next = (key < rdata) ? S_DONE : S_ICHK;
      S_ICHK: begin
        if (key > rdata) begin
          state_next = S_DONE;
        end else if (rdata == el) begin
          state_next = S_IPROBE;
        end else begin
          state_next = S_IMUL;
        end
      end
      S_IMUL:   state_next = S_IDIV;
      S_IDIV:   state_next = div_done ? S_IPROBE : S_IDIV;
      S_IPROBE: state_next = S_CMP;
      S_CMP: begin
        if (rdata == key) begin
          state_next = S_DONE;
        end else begin
          state_next = (method == METHOD_INTERP) ? S_ILO : S_BPROBE;
        end
      end
      S_DONE:   state_next = load_result ? S_IDLE : S_DONE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Search datapath: bounds, key, end entries, probe
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        lo        <= '0;
        hi        <= n_sat - ONE;
        key       <= value;
        res_found <= 1'b0;
        res_pos   <= '0;
      end
      S_BPROBE: probe <= mid[AW-1:0];
      S_IHI:    el    <= rdata;
      S_ICHK: begin
        den   <= end_diff[VALUE_W-1:0];
        kdiff <= key_diff[VALUE_W-1:0];
        qoff  <= '0;
      end
      S_IDIV: begin
        if (div_done) begin
          qoff <= div_quot;
        end
      end
      S_IPROBE: probe <= raddr;
      S_CMP: begin
        if (rdata == key) begin
          res_found <= 1'b1;
          res_pos   <= INDEX_W'(probe);
        end else if (rdata < key) begin
          lo <= probe_i + ONE;
        end else begin
          hi <= probe_i - ONE;
        end
      end
      default: lo <= lo;
    endcase
  end

  // Result register: load when empty or being drained
  assign load_result = (state == S_DONE) && (!result_valid || !result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_result) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      found    <= res_found;
      position <= res_pos;
    end
  end

  assign item_stall = (state != S_IDLE);

endmodule
